FILE: sv/dlq_pkg.sv
`timescale 1ns / 1ps

package dlq_pkg;

    // Widest link code the pool size range can need (1024 nodes plus null).
    localparam int LINK_W_MAX = 11;

    typedef enum logic [2:0] {
        ACT_APPEND_CHK  = 3'd0,
        ACT_APPEND_FAST = 3'd1,
        ACT_INSERT      = 3'd2,
        ACT_TAKE_FIRST  = 3'd3,
        ACT_TAKE_AT     = 3'd4,
        ACT_REMOVE      = 3'd5,
        ACT_READ_AT     = 3'd6,
        ACT_CLEAR       = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_FIND,
        S_WALK,
        S_AP_NEXT,
        S_AP_PREV,
        S_AP_TAIL,
        S_IB_READ,
        S_IB_W1,
        S_IB_W2,
        S_IB_W3,
        S_IB_W4,
        S_TF_READ,
        S_TF_FIX,
        S_TF_CLR,
        S_UL_READ,
        S_UL_W1,
        S_UL_W2,
        S_UL_CLR,
        S_CLEAR,
        S_FIN
    } t_state;

    // Broadcast command seen by every link cell.
    typedef struct packed {
        logic [LINK_W_MAX-1:0] rd_node;
        logic                  wr_next;
        logic                  wr_prev;
        logic [LINK_W_MAX-1:0] wr_node;
        logic [LINK_W_MAX-1:0] wr_val;
    } t_cell_cmd;

endpackage

FILE: sv/dlq_cell.sv
`timescale 1ns / 1ps

// Link storage for one node. Read data rides an OR chain from cell to cell.
module dlq_cell import dlq_pkg::*; #(
    parameter int LINK_W = 5,
    parameter int IDX    = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [LINK_W-1:0] i_chain_next,
    input  logic [LINK_W-1:0] i_chain_prev,
    output logic [LINK_W-1:0] o_chain_next,
    output logic [LINK_W-1:0] o_chain_prev
);

    localparam logic [LINK_W-1:0] MY_ID = LINK_W'(IDX);

    logic [LINK_W-1:0] r_next;
    logic [LINK_W-1:0] r_prev;
    logic              w_rd_hit;
    logic              w_wr_hit;

    assign w_rd_hit = (i_cmd.rd_node[LINK_W-1:0] == MY_ID);
    assign w_wr_hit = (i_cmd.wr_node[LINK_W-1:0] == MY_ID);

    always_ff @(posedge i_clk) begin
        if (w_wr_hit && i_cmd.wr_next) begin
            r_next <= i_cmd.wr_val[LINK_W-1:0];
        end
        if (w_wr_hit && i_cmd.wr_prev) begin
            r_prev <= i_cmd.wr_val[LINK_W-1:0];
        end
    end

    assign o_chain_next = i_chain_next | (w_rd_hit ? r_next : '0);
    assign o_chain_prev = i_chain_prev | (w_rd_hit ? r_prev : '0);

endmodule

FILE: sv/doubly_linked_queue_manager.sv
`timescale 1ns / 1ps

// Doubly linked queue manager. Keeps an ordered list over node ids
// 0..NODE_COUNT-1 with per-node next/prev links held in a row of link cells
// (one cell per node), plus head, tail and member count. Each accepted input
// word yields exactly one result word: status (done / already present /
// not found), the node taken or read, and the member count afterwards.
// One action at a time: o_in_ready is high only while the sequencer is idle,
// but a finished result may still wait in the output register while the next
// word is taken. The sequencer follows one link per cycle through the cell
// row's single read path, and performs one link write per cycle. Link storage
// is not cleared at reset; only head, tail and count are.
module doubly_linked_queue_manager import dlq_pkg::*; #(
    parameter int NODE_COUNT = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic [3:0] i_node_id,
    input  logic [3:0] i_ref_node,
    input  logic [3:0] i_position,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [3:0] o_node_out,
    output logic [4:0] o_count_out
);

    // link code width: ids plus the null code NODE_COUNT
    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam int XW = (LW > 4) ? LW : 4;
    localparam int YW = (LW > 5) ? LW : 5;
    localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);

    t_state  r_state, n_state;
    t_action r_act;
    logic [3:0]    r_nid, r_ref, r_pos;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_e, n_e;
    logic [LW-1:0] r_p, n_p;
    logic [LW-1:0] r_nx, n_nx;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_count, n_count;
    t_status       r_fin_st, n_fin_st;
    logic [LW-1:0] r_fin_node, n_fin_node;

    // output register
    logic          r_out_valid, n_out_valid;
    t_status       r_status, n_status;
    logic [LW-1:0] r_node_out, n_node_out;
    logic [LW-1:0] r_count_out, n_count_out;

    t_cell_cmd     w_cmd;
    logic [LW-1:0] w_rd_next, w_rd_prev;
    logic [LW-1:0] w_chain_next [NODE_COUNT+1];
    logic [LW-1:0] w_chain_prev [NODE_COUNT+1];

    logic          w_accept;
    logic          w_nid_ok, w_ref_ok, w_pos_ok;
    logic [LW-1:0] w_nid, w_ref;
    logic          w_empty;
    logic          w_cur_ok, w_walk_end, w_find_end;
    logic          w_out_free;
    logic [LW-1:0] w_cnt_up, w_cnt_dn;
    logic [XW-1:0] w_node_x;
    logic [YW-1:0] w_count_x;

    // ---------------- link cell row ----------------
    assign w_chain_next[0] = '0;
    assign w_chain_prev[0] = '0;

    for (genvar g = 0; g < NODE_COUNT; g++) begin : g_cell
        dlq_cell #(
            .LINK_W (LW),
            .IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_chain_next (w_chain_next[g]),
            .i_chain_prev (w_chain_prev[g]),
            .o_chain_next (w_chain_next[g+1]),
            .o_chain_prev (w_chain_prev[g+1])
        );
    end

    assign w_rd_next = w_chain_next[NODE_COUNT];
    assign w_rd_prev = w_chain_prev[NODE_COUNT];

    // ---------------- common decode ----------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_nid    = LW'(r_nid);
    assign w_ref    = LW'(r_ref);
    assign w_nid_ok = XW'(r_nid) < XW'(NODE_COUNT);
    assign w_ref_ok = XW'(r_ref) < XW'(NODE_COUNT);
    assign w_pos_ok = XW'(r_pos) < XW'(r_count);
    assign w_empty  = !(r_head < NULL_LINK) && !(r_tail < NULL_LINK);
    assign w_cur_ok = r_cur < NULL_LINK;
    // walk stops on position reached or a broken chain
    assign w_walk_end = (r_cnt == '0) || !w_cur_ok;
    // search stops after NODE_COUNT steps or at the list end
    assign w_find_end = (r_cnt == NULL_LINK) || !w_cur_ok;

    assign w_cnt_up = (r_count < NULL_LINK) ? LW'(r_count + 1'b1) : r_count;
    assign w_cnt_dn = (r_count != '0) ? LW'(r_count - 1'b1) : r_count;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DISP;
            end
            S_DISP: begin
                case (r_act)
                    ACT_APPEND_CHK:  n_state = w_nid_ok ? S_FIND : S_FIN;
                    ACT_APPEND_FAST: n_state = w_nid_ok ? S_AP_NEXT : S_FIN;
                    ACT_INSERT:      n_state = (w_nid_ok && w_ref_ok) ? S_IB_READ : S_FIN;
                    ACT_TAKE_FIRST:  n_state = (r_head < NULL_LINK) ? S_TF_READ : S_FIN;
                    ACT_TAKE_AT:     n_state = w_pos_ok ? S_WALK : S_FIN;
                    ACT_READ_AT:     n_state = w_pos_ok ? S_WALK : S_FIN;
                    ACT_REMOVE:      n_state = w_nid_ok ? S_FIND : S_FIN;
                    ACT_CLEAR:       n_state = S_CLEAR;
                    default:         n_state = S_FIN;
                endcase
            end
            S_FIND: begin
                if (w_find_end) begin
                    n_state = (r_act == ACT_APPEND_CHK) ? S_AP_NEXT : S_FIN;
                end else if (r_cur == w_nid) begin
                    n_state = (r_act == ACT_REMOVE) ? S_UL_READ : S_FIN;
                end
            end
            S_WALK: begin
                if (w_walk_end) begin
                    n_state = (w_cur_ok && r_act == ACT_TAKE_AT) ? S_UL_READ : S_FIN;
                end
            end
            S_AP_NEXT: n_state = S_AP_PREV;
            S_AP_PREV: n_state = S_AP_TAIL;
            S_AP_TAIL: n_state = S_FIN;
            S_IB_READ: n_state = S_IB_W1;
            S_IB_W1:   n_state = S_IB_W2;
            S_IB_W2:   n_state = S_IB_W3;
            S_IB_W3:   n_state = S_IB_W4;
            S_IB_W4:   n_state = S_FIN;
            S_TF_READ: n_state = (r_head == r_tail) ? S_TF_CLR : S_TF_FIX;
            S_TF_FIX:  n_state = S_TF_CLR;
            S_TF_CLR:  n_state = S_FIN;
            S_UL_READ: n_state = S_UL_W1;
            S_UL_W1:   n_state = S_UL_W2;
            S_UL_W2:   n_state = S_UL_CLR;
            S_UL_CLR:  n_state = S_FIN;
            S_CLEAR: begin
                if (w_find_end) n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and cell commands ----------------
    always_comb begin
        n_cur      = r_cur;
        n_cnt      = r_cnt;
        n_e        = r_e;
        n_p        = r_p;
        n_nx       = r_nx;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_fin_st   = r_fin_st;
        n_fin_node = r_fin_node;

        w_cmd         = '0;
        w_cmd.rd_node = LINK_W_MAX'(r_cur);
        w_cmd.wr_node = LINK_W_MAX'(NULL_LINK);

        case (r_state)
            S_DISP: begin
                n_fin_st   = ST_NOT_FOUND;
                n_fin_node = '0;
                n_cur      = r_head;
                n_cnt      = ((r_act == ACT_TAKE_AT) || (r_act == ACT_READ_AT))
                           ? LW'(r_pos) : '0;
            end
            S_FIND: begin
                if (w_find_end) begin
                    n_fin_st = ST_NOT_FOUND;
                end else if (r_cur == w_nid) begin
                    n_fin_st = ST_PRESENT;
                    n_e      = w_nid;
                end else begin
                    n_cur = w_rd_next;
                    n_cnt = LW'(r_cnt + 1'b1);
                end
            end
            S_WALK: begin
                if (w_walk_end) begin
                    n_e = r_cur;
                    if (w_cur_ok && r_act == ACT_READ_AT) begin
                        n_fin_st   = ST_DONE;
                        n_fin_node = r_cur;
                    end
                end else begin
                    n_cur = w_rd_next;
                    n_cnt = LW'(r_cnt - 1'b1);
                end
            end
            S_AP_NEXT: begin
                w_cmd.wr_node = LINK_W_MAX'(w_nid);
                w_cmd.wr_next = 1'b1;
                w_cmd.wr_val  = LINK_W_MAX'(NULL_LINK);
            end
            S_AP_PREV: begin
                w_cmd.wr_node = LINK_W_MAX'(w_nid);
                w_cmd.wr_prev = 1'b1;
                w_cmd.wr_val  = LINK_W_MAX'(w_empty ? NULL_LINK : r_tail);
            end
            S_AP_TAIL: begin
                // tail link skipped when tail is null but head is not
                w_cmd.wr_node = LINK_W_MAX'(r_tail);
                w_cmd.wr_next = !w_empty && (r_tail < NULL_LINK);
                w_cmd.wr_val  = LINK_W_MAX'(w_nid);
                if (w_empty) n_head = w_nid;
                n_tail   = w_nid;
                n_count  = w_cnt_up;
                n_fin_st = ST_DONE;
            end
            S_IB_READ: begin
                w_cmd.rd_node = LINK_W_MAX'(w_ref);
                n_p           = w_rd_prev;
            end
            S_IB_W1: begin
                w_cmd.wr_node = LINK_W_MAX'(r_p);
                w_cmd.wr_next = (r_p < NULL_LINK);
                w_cmd.wr_val  = LINK_W_MAX'(w_nid);
                if (!(r_p < NULL_LINK)) n_head = w_nid;
            end
            S_IB_W2: begin
                w_cmd.wr_node = LINK_W_MAX'(w_nid);
                w_cmd.wr_next = 1'b1;
                w_cmd.wr_val  = LINK_W_MAX'(w_ref);
            end
            S_IB_W3: begin
                w_cmd.wr_node = LINK_W_MAX'(w_nid);
                w_cmd.wr_prev = 1'b1;
                w_cmd.wr_val  = LINK_W_MAX'(r_p);
            end
            S_IB_W4: begin
                w_cmd.wr_node = LINK_W_MAX'(w_ref);
                w_cmd.wr_prev = 1'b1;
                w_cmd.wr_val  = LINK_W_MAX'(w_nid);
                n_count       = w_cnt_up;
                n_fin_st      = ST_DONE;
            end
            S_TF_READ: begin
                w_cmd.rd_node = LINK_W_MAX'(r_head);
                n_e           = r_head;
                if (r_head == r_tail) begin
                    n_head = NULL_LINK;
                    n_tail = NULL_LINK;
                end else begin
                    n_head = w_rd_next;
                    n_nx   = w_rd_next;
                end
            end
            S_TF_FIX: begin
                w_cmd.wr_node = LINK_W_MAX'(r_nx);
                w_cmd.wr_prev = (r_nx < NULL_LINK);
                w_cmd.wr_val  = LINK_W_MAX'(NULL_LINK);
            end
            S_TF_CLR: begin
                w_cmd.wr_node = LINK_W_MAX'(r_e);
                w_cmd.wr_next = 1'b1;
                w_cmd.wr_prev = 1'b1;
                w_cmd.wr_val  = LINK_W_MAX'(NULL_LINK);
                n_count       = w_cnt_dn;
                n_fin_st      = ST_DONE;
                n_fin_node    = r_e;
            end
            S_UL_READ: begin
                w_cmd.rd_node = LINK_W_MAX'(r_e);
                n_p           = w_rd_prev;
                n_nx          = w_rd_next;
                if (r_head == r_e) n_head = w_rd_next;
                if (r_tail == r_e) n_tail = w_rd_prev;
            end
            S_UL_W1: begin
                w_cmd.wr_node = LINK_W_MAX'(r_p);
                w_cmd.wr_next = (r_p < NULL_LINK);
                w_cmd.wr_val  = LINK_W_MAX'(r_nx);
            end
            S_UL_W2: begin
                w_cmd.wr_node = LINK_W_MAX'(r_nx);
                w_cmd.wr_prev = (r_nx < NULL_LINK);
                w_cmd.wr_val  = LINK_W_MAX'(r_p);
            end
            S_UL_CLR: begin
                w_cmd.wr_node = LINK_W_MAX'(r_e);
                w_cmd.wr_next = 1'b1;
                w_cmd.wr_prev = 1'b1;
                w_cmd.wr_val  = LINK_W_MAX'(NULL_LINK);
                n_count       = w_cnt_dn;
                n_fin_st      = ST_DONE;
                n_fin_node    = (r_act == ACT_TAKE_AT) ? r_e : '0;
            end
            S_CLEAR: begin
                if (w_find_end) begin
                    n_head   = NULL_LINK;
                    n_tail   = NULL_LINK;
                    n_count  = '0;
                    n_fin_st = ST_DONE;
                end else begin
                    // read the successor and wipe this node in the same cycle
                    w_cmd.wr_node = LINK_W_MAX'(r_cur);
                    w_cmd.wr_next = 1'b1;
                    w_cmd.wr_prev = 1'b1;
                    w_cmd.wr_val  = LINK_W_MAX'(NULL_LINK);
                    n_cur         = w_rd_next;
                    n_cnt         = LW'(r_cnt + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- output register ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_node_out  = r_node_out;
        n_count_out = r_count_out;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (r_state == S_FIN && w_out_free) begin
            n_out_valid = 1'b1;
            n_status    = r_fin_st;
            n_node_out  = r_fin_node;
            n_count_out = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= NULL_LINK;
            r_tail      <= NULL_LINK;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= t_action'(i_action);
            r_nid <= i_node_id;
            r_ref <= i_ref_node;
            r_pos <= i_position;
        end
        r_cur       <= n_cur;
        r_cnt       <= n_cnt;
        r_e         <= n_e;
        r_p         <= n_p;
        r_nx        <= n_nx;
        r_fin_st    <= n_fin_st;
        r_fin_node  <= n_fin_node;
        r_status    <= n_status;
        r_node_out  <= n_node_out;
        r_count_out <= n_count_out;
    end

    assign w_node_x    = XW'(r_node_out);
    assign w_count_x   = YW'(r_count_out);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_node_out  = w_node_x[3:0];
    assign o_count_out = w_count_x[4:0];

endmodule

FILE: sv/dlq_checker.sv
`timescale 1ns / 1ps

module dlq_props import dlq_pkg::*; #(
    parameter int NODE_COUNT = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [2:0] i_action,
    input logic [3:0] i_node_id,
    input logic [3:0] i_ref_node,
    input logic [3:0] i_position,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic [3:0] o_node_out,
    input logic [4:0] o_count_out
);

    localparam logic [4:0] CNT_CAP = (NODE_COUNT > 16) ? 5'd16 : 5'(NODE_COUNT);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_node_out)
            && $stable(o_count_out))
        else $error("result word changed while stalled");

    // one action at a time: ready drops right after a word is taken
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_DONE) || (o_status == ST_PRESENT)
                        || (o_status == ST_NOT_FOUND))
        else $error("illegal status code");

    a_node_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DONE) |-> (o_node_out == 4'd0))
        else $error("node_out nonzero on failed action");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count_out <= CNT_CAP))
        else $error("member count above pool size");

endmodule

bind doubly_linked_queue_manager dlq_props #(.NODE_COUNT(NODE_COUNT)) u_dlq_props (.*);

FILE: tb/dlq_checker.sv
`timescale 1ns / 1ps

module dlq_checker import dlq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [2:0] i_action,
    input  logic [3:0] i_node_id,
    input  logic [3:0] i_ref_node,
    input  logic [3:0] i_position,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_status,
    input  logic [3:0] i_node_out,
    input  logic [4:0] i_count_out,
    output int         o_fail_count,
    output int         o_outstanding
);

    localparam int         NODES      = 16;
    localparam logic [4:0] NIL        = 5'd16;

    typedef struct packed {
        t_status    status;
        logic [3:0] node;
        logic [4:0] count;
    } t_list_result;

    // Shadow of the list: links, ends and member count.
    logic [4:0] next_of [NODES];
    logic [4:0] prev_of [NODES];
    logic [4:0] head;
    logic [4:0] tail;
    logic [4:0] members;

    t_list_result results_due[$];
    int           fails = 0;

    function automatic bit valid_id(logic [4:0] v);
        return v < NODES;
    endfunction

    function automatic void grow();
        if (members < NODES) members++;
    endfunction

    function automatic void shrink();
        if (members > 0) members--;
    endfunction

    function automatic void link_at_tail(logic [4:0] n);
        if (!valid_id(head) && !valid_id(tail)) begin
            head = n;
            tail = n;
            next_of[n[3:0]] = NIL;
            prev_of[n[3:0]] = NIL;
        end else begin
            next_of[n[3:0]] = NIL;
            prev_of[n[3:0]] = tail;
            if (valid_id(tail)) next_of[tail[3:0]] = n;
            tail = n;
        end
        grow();
    endfunction

    function automatic void splice_out(logic [4:0] e);
        logic [4:0] p;
        logic [4:0] nx;
        p  = prev_of[e[3:0]];
        nx = next_of[e[3:0]];
        if (head == e) head = nx;
        if (tail == e) tail = p;
        if (valid_id(p)) next_of[p[3:0]] = nx;
        if (valid_id(nx)) prev_of[nx[3:0]] = p;
        shrink();
        next_of[e[3:0]] = NIL;
        prev_of[e[3:0]] = NIL;
    endfunction

    function automatic logic [4:0] locate_pos(logic [3:0] pos);
        logic [4:0] cur;
        int         k;
        if (pos >= members) return NIL;
        cur = head;
        k   = pos;
        while (k != 0 && valid_id(cur)) begin
            cur = next_of[cur[3:0]];
            k--;
        end
        return valid_id(cur) ? cur : NIL;
    endfunction

    // Walk from head, bounded to the pool size.
    function automatic bit is_listed(logic [4:0] n);
        logic [4:0] cur;
        cur = head;
        for (int steps = 0; steps < NODES && valid_id(cur); steps++) begin
            if (cur == n) return 1'b1;
            cur = next_of[cur[3:0]];
        end
        return 1'b0;
    endfunction

    function automatic t_list_result apply_list_action(t_action act, logic [3:0] nid,
                                                       logic [3:0] rid, logic [3:0] pos);
        t_list_result res;
        logic [4:0]   n;
        logic [4:0]   r;
        logic [4:0]   e;
        logic [4:0]   p;
        logic [4:0]   cur;
        n          = {1'b0, nid};
        r          = {1'b0, rid};
        res.status = ST_NOT_FOUND;
        res.node   = '0;
        case (act)
            ACT_APPEND_CHK: begin
                if (is_listed(n)) begin
                    res.status = ST_PRESENT;
                end else begin
                    link_at_tail(n);
                    res.status = ST_DONE;
                end
            end
            ACT_APPEND_FAST: begin
                link_at_tail(n);
                res.status = ST_DONE;
            end
            ACT_INSERT: begin
                // blind splice; order of writes matters when ids coincide
                p = prev_of[r[3:0]];
                if (valid_id(p)) next_of[p[3:0]] = n;
                else head = n;
                next_of[n[3:0]] = r;
                prev_of[n[3:0]] = p;
                prev_of[r[3:0]] = n;
                grow();
                res.status = ST_DONE;
            end
            ACT_TAKE_FIRST: begin
                if (valid_id(head)) begin
                    e = head;
                    if (head == tail) begin
                        head = NIL;
                        tail = NIL;
                    end else begin
                        head = next_of[e[3:0]];
                        if (valid_id(head)) prev_of[head[3:0]] = NIL;
                    end
                    shrink();
                    next_of[e[3:0]] = NIL;
                    prev_of[e[3:0]] = NIL;
                    res.status = ST_DONE;
                    res.node   = e[3:0];
                end
            end
            ACT_TAKE_AT: begin
                e = locate_pos(pos);
                if (valid_id(e)) begin
                    splice_out(e);
                    res.status = ST_DONE;
                    res.node   = e[3:0];
                end
            end
            ACT_REMOVE: begin
                if (is_listed(n)) begin
                    splice_out(n);
                    res.status = ST_DONE;
                end
            end
            ACT_READ_AT: begin
                e = locate_pos(pos);
                if (valid_id(e)) begin
                    res.status = ST_DONE;
                    res.node   = e[3:0];
                end
            end
            ACT_CLEAR: begin
                cur = head;
                for (int steps = 0; steps < NODES && valid_id(cur); steps++) begin
                    e   = cur;
                    cur = next_of[e[3:0]];
                    next_of[e[3:0]] = NIL;
                    prev_of[e[3:0]] = NIL;
                end
                head       = NIL;
                tail       = NIL;
                members    = '0;
                res.status = ST_DONE;
            end
            default: ;
        endcase
        res.count = members;
        return res;
    endfunction

    task automatic note_mismatch(string field, logic [4:0] want_v, logic [4:0] got_v);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : watch
        t_list_result got;
        t_list_result want;
        bit           bad;
        if (!i_rst_n) begin
            for (int k = 0; k < NODES; k++) begin
                next_of[k] = '0;
                prev_of[k] = '0;
            end
            head    = NIL;
            tail    = NIL;
            members = '0;
            results_due.delete();
        end else begin
            // result side first: the oldest expectation belongs to an earlier word
            if (i_out_valid && i_out_ready) begin
                got = '{t_status'(i_status), i_node_out, i_count_out};
                if (results_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word: status %0d node %0d count %0d",
                             $time, i_status, i_node_out, i_count_out);
                end else begin
                    want = results_due.pop_front();
                    bad  = 1'b0;
                    if (got.status !== want.status) begin
                        bad = 1'b1;
                        note_mismatch("status", 5'(want.status), 5'(got.status));
                    end
                    if (got.node !== want.node) begin
                        bad = 1'b1;
                        note_mismatch("node_out", 5'(want.node), 5'(got.node));
                    end
                    if (got.count !== want.count) begin
                        bad = 1'b1;
                        note_mismatch("count_out", want.count, got.count);
                    end
                    if (bad) fails++;
                end
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(apply_list_action(t_action'(i_action), i_node_id,
                                                        i_ref_node, i_position));
        end
        o_fail_count  <= fails;
        o_outstanding <= results_due.size();
    end

endmodule

FILE: tb/tb_doubly_linked_queue_manager.sv
`timescale 1ns / 1ps

module tb_doubly_linked_queue_manager;
    import dlq_pkg::*;

    localparam int RANDOM_WORDS = 1750;
    // No handshake on either side for this long means the block is hung.
    // Worst legal stretch is a long sender gap overlapping the slowest action
    // and a long receiver stall.
    localparam int IDLE_LIMIT   = 3000;
    // Settle time after the last result, beyond the slowest action.
    localparam int DRAIN_TAIL   = 64;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] action;
    logic [3:0] node_id;
    logic [3:0] ref_node;
    logic [3:0] position;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [3:0] node_out;
    logic [4:0] count_out;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;

    // When set, neither side inserts gaps.
    bit calm = 1'b0;

    // Stimulus-side view of list order, good only while no misuse word has
    // been sent since the last clear. Used to shape well-formed sequences.
    logic [3:0] roster[$];
    bit         roster_bad = 1'b0;
    // Nodes whose link entries have been written at least once. Insert
    // reads the reference node's links, so only these may serve as reference.
    bit         written [16];

    doubly_linked_queue_manager #(.NODE_COUNT(16)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_action    (action),
        .i_node_id   (node_id),
        .i_ref_node  (ref_node),
        .i_position  (position),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_status    (status),
        .o_node_out  (node_out),
        .o_count_out (count_out)
    );

    dlq_checker list_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_action      (action),
        .i_node_id     (node_id),
        .i_ref_node    (ref_node),
        .i_position    (position),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_node_out    (node_out),
        .i_count_out   (count_out),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic int roster_index(logic [3:0] n);
        foreach (roster[k])
            if (roster[k] == n) return k;
        return -1;
    endfunction

    function automatic logic [3:0] pick_absent();
        logic [3:0] n;
        do n = $urandom_range(0, 15); while (roster_index(n) >= 0);
        return n;
    endfunction

    function automatic logic [3:0] any_written();
        logic [3:0] n;
        do n = $urandom_range(0, 15); while (!written[n]);
        return n;
    endfunction

    // Present one word at a falling edge, hold it until taken, and return at
    // the next falling edge. Valid stays high when the next word follows
    // right away; otherwise it drops here for the gap.
    task automatic send_word(t_action act, logic [3:0] nid, logic [3:0] rid,
                             logic [3:0] pos);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action   = act;
        node_id  = nid;
        ref_node = rid;
        position = pos;
        in_valid = 1'b1;
        // appends and inserts write both links of the new node
        if (act == ACT_APPEND_CHK || act == ACT_APPEND_FAST || act == ACT_INSERT)
            written[nid] = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Random word. While the roster is trusted, mostly well-formed actions
    // with random content; a small share of misuse (fast append of a member,
    // insert of a member, or a random insert before any written node) breaks it
    // until the next clear, and meanwhile actions are plain noise.
    task automatic make_word(output t_action act, output logic [3:0] nid,
                             output logic [3:0] rid, output logic [3:0] pos);
        int sz;
        int r;
        int idx;
        sz  = roster.size();
        act = ACT_READ_AT;
        nid = $urandom_range(0, 15);
        rid = $urandom_range(0, 15);
        pos = $urandom_range(0, 15);
        r   = $urandom_range(0, 99);
        if (roster_bad) begin
            act = t_action'($urandom_range(0, 7));
            if (act == ACT_INSERT) rid = any_written();
            if (act == ACT_CLEAR) begin
                roster.delete();
                roster_bad = 1'b0;
            end
        end else if (r < 3 && sz > 0) begin
            roster_bad = 1'b1;
            case ($urandom_range(0, 2))
                0: begin
                    act = ACT_APPEND_FAST;
                    nid = roster[$urandom_range(0, sz - 1)];
                end
                1: begin
                    act = ACT_INSERT;
                    nid = roster[$urandom_range(0, sz - 1)];
                    rid = roster[$urandom_range(0, sz - 1)];
                end
                default: begin
                    act = ACT_INSERT;
                    rid = any_written();
                end
            endcase
        end else if (r < 35) begin
            if (sz == 16 || $urandom_range(0, 1) == 0) begin
                act = ACT_APPEND_CHK;
                if (sz > 0 && $urandom_range(0, 2) == 0) nid = roster[$urandom_range(0, sz - 1)];
                if (roster_index(nid) < 0) roster.push_back(nid);
            end else begin
                act = ACT_APPEND_FAST;
                nid = pick_absent();
                roster.push_back(nid);
            end
        end else if (r < 50 && sz > 0 && sz < 16) begin
            act = ACT_INSERT;
            nid = pick_absent();
            idx = $urandom_range(0, sz - 1);
            rid = roster[idx];
            roster.insert(idx, nid);
        end else if (r < 58) begin
            act = ACT_TAKE_FIRST;
            if (sz > 0) roster.delete(0);
        end else if (r < 68) begin
            act = ACT_TAKE_AT;
            if (sz > 0 && $urandom_range(0, 3) != 0) pos = $urandom_range(0, sz - 1);
            if (pos < sz) roster.delete(pos);
        end else if (r < 78) begin
            act = ACT_REMOVE;
            if (sz > 0 && $urandom_range(0, 1) == 0) nid = roster[$urandom_range(0, sz - 1)];
            idx = roster_index(nid);
            if (idx >= 0) roster.delete(idx);
        end else if (r < 98) begin
            act = ACT_READ_AT;
            if (sz > 0 && $urandom_range(0, 3) != 0) pos = $urandom_range(0, sz - 1);
        end else begin
            act = ACT_CLEAR;
            roster.delete();
        end
    endtask

    initial begin : stimulus
        t_action    act;
        logic [3:0] nid;
        logic [3:0] rid;
        logic [3:0] pos;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = ACT_APPEND_CHK;
        node_id  = '0;
        ref_node = '0;
        position = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty list: every lookup reports not found, clear still succeeds.
        send_word(ACT_TAKE_FIRST, 4'd0, 4'd0, 4'd0);
        send_word(ACT_TAKE_AT, 4'd0, 4'd0, 4'd0);
        send_word(ACT_READ_AT, 4'd0, 4'd0, 4'd15);
        send_word(ACT_REMOVE, 4'd15, 4'd0, 4'd0);
        send_word(ACT_CLEAR, 4'd0, 4'd0, 4'd0);
        // Build 3,0,9,15,7 with both id extremes, a duplicate and both inserts.
        send_word(ACT_APPEND_CHK, 4'd0, 4'd0, 4'd0);
        send_word(ACT_APPEND_CHK, 4'd15, 4'd0, 4'd0);
        send_word(ACT_APPEND_CHK, 4'd0, 4'd0, 4'd0);
        send_word(ACT_APPEND_FAST, 4'd7, 4'd0, 4'd0);
        send_word(ACT_INSERT, 4'd3, 4'd0, 4'd0);
        send_word(ACT_INSERT, 4'd9, 4'd15, 4'd0);
        // head, tail, one past the end, position all ones
        send_word(ACT_READ_AT, 4'd0, 4'd0, 4'd0);
        send_word(ACT_READ_AT, 4'd0, 4'd0, 4'd4);
        send_word(ACT_READ_AT, 4'd0, 4'd0, 4'd5);
        send_word(ACT_READ_AT, 4'd0, 4'd0, 4'd15);
        send_word(ACT_TAKE_AT, 4'd0, 4'd0, 4'd2);
        send_word(ACT_TAKE_AT, 4'd0, 4'd0, 4'd15);
        send_word(ACT_REMOVE, 4'd15, 4'd0, 4'd0);
        send_word(ACT_REMOVE, 4'd12, 4'd0, 4'd0);
        send_word(ACT_TAKE_FIRST, 4'd0, 4'd0, 4'd0);
        // Fast append of a member: tail links to itself, walk loops on 7.
        send_word(ACT_APPEND_FAST, 4'd7, 4'd0, 4'd0);
        send_word(ACT_READ_AT, 4'd0, 4'd0, 4'd2);
        // Insert before a node no longer in the list.
        send_word(ACT_INSERT, 4'd15, 4'd3, 4'd0);
        send_word(ACT_CLEAR, 4'd0, 4'd0, 4'd0);
        roster.delete();
        roster_bad = 1'b0;

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= 600 && i < 800);
            // now and then hold off until the block has answered everything
            if (i % 300 == 150) begin
                in_valid = 1'b0;
                do @(negedge clk); while (outstanding != 0);
            end
            make_word(act, nid, rid, pos);
            send_word(act, nid, rid, pos);
        end
        in_valid = 1'b0;

        do @(negedge clk); while (outstanding != 0);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS doubly_linked_queue_manager");
        else
            $display("FAIL doubly_linked_queue_manager");
        $finish;
    end

    // Result side: ready runs of random length, broken by stalls drawn like
    // the sender's gaps (none at all while calm).
    initial begin : receiver
        int run_left;
        int stall;
        out_ready = 1'b0;
        run_left  = 0;
        forever begin
            @(negedge clk);
            if (run_left != 0) begin
                run_left--;
            end else if (out_ready) begin
                stall = pick_gap();
                if (stall != 0) begin
                    out_ready = 1'b0;
                    run_left  = stall - 1;
                end else begin
                    run_left = $urandom_range(0, 15);
                end
            end else begin
                out_ready = 1'b1;
                run_left  = $urandom_range(0, 15);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL doubly_linked_queue_manager");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
